// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the command framer rtl
// no dependencies; define SYNTH to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LKPCF_CHK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lkpcf check failed");
`define LKPCF_CHK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lkpcf check failed");
`else
`define LKPCF_CHK(lbl, clk, rst, prop)
`define LKPCF_CHK_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/lkpcf_pkg.sv -----
// types, codes and tables of the led/key panel command framer
// no dependencies
package lkpcf_pkg;

  localparam int RAM_BYTES   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_W       = 14;  // holds 0..9999
  localparam int STEP_W      = 5;   // byte index within one request, up to 17

  // request op codes
  localparam logic [2:0] OP_SET_DIGIT  = 3'd0;
  localparam logic [2:0] OP_SET_NUMBER = 3'd1;
  localparam logic [2:0] OP_SET_LED    = 3'd2;
  localparam logic [2:0] OP_BRIGHTNESS = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;
  localparam logic [2:0] OP_RESET      = 3'd5;
  localparam logic [2:0] OP_SCAN       = 3'd6;

  // job kinds between front and back
  localparam logic [2:0] KIND_PAIR   = 3'd0;  // address byte then data byte
  localparam logic [2:0] KIND_SINGLE = 3'd1;  // one byte framed alone
  localparam logic [2:0] KIND_NUMBER = 3'd2;  // decimal digits, one frame each
  localparam logic [2:0] KIND_CLEAR  = 3'd3;  // blank every digit
  localparam logic [2:0] KIND_RESET  = 3'd4;  // mode byte, then ram wipe

  // chip command bytes
  localparam logic [7:0] CMD_AUTO_INC   = 8'h40;
  localparam logic [7:0] CMD_READ_KEYS  = 8'h42;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
  localparam logic [7:0] ADDR_DIGIT     = 8'hC0;
  localparam logic [7:0] ADDR_LED       = 8'hC1;
  localparam logic [7:0] BYTE_BLANK     = 8'h00;

  localparam logic [15:0] NUMBER_MAX  = 16'd9999;
  localparam logic [15:0] DIGIT_MAX   = 16'd9;
  localparam logic [15:0] LED_MAX     = 16'd255;
  localparam logic [15:0] LEVEL_MAX   = 16'd7;
  localparam logic [12:0] DIV10_RECIP = 13'd6554;  // ceil(2^16 / 10)

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       addr;
    logic [7:0]       data;
    logic [3:0]       key;
    logic [NUM_W-1:0] number;
  } job_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    case (d)
      4'd0:    seg_code = 8'h3F;
      4'd1:    seg_code = 8'h06;
      4'd2:    seg_code = 8'h5B;
      4'd3:    seg_code = 8'h4F;
      4'd4:    seg_code = 8'h66;
      4'd5:    seg_code = 8'h6D;
      4'd6:    seg_code = 8'h7D;
      4'd7:    seg_code = 8'h07;
      4'd8:    seg_code = 8'h7F;
      4'd9:    seg_code = 8'h6F;
      default: seg_code = 8'h00;
    endcase
  endfunction

  // first hit in read order: bit 0 gives the odd key, bit 4 the even one
  function automatic logic [3:0] decode_keys(input logic [31:0] kb);
    logic [3:0] k;
    logic       found;
    k     = 4'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && kb[8*i]) begin
        k     = 4'(2 * i + 1);
        found = 1'b1;
      end else if (!found && kb[8*i+4]) begin
        k     = 4'(2 * i + 2);
        found = 1'b1;
      end
    end
    decode_keys = k;
  endfunction

endpackage

// ----- hw/rtl/lkpcf_if.sv -----
// request and byte channels of the command framer
// depends on nothing but the handshake convention valid/ready
interface lkpcf_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  position;
  logic [15:0] value;
  logic [31:0] key_bytes;

  modport source (output valid, op, position, value, key_bytes, input ready);
  modport sink   (input valid, op, position, value, key_bytes, output ready);
endinterface

interface lkpcf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       frame_start;
  logic       frame_end;
  logic [3:0] key_code;
  logic       last;

  modport source (output valid, bus_byte, frame_start, frame_end, key_code, last,
                  input ready);
  modport sink   (input valid, bus_byte, frame_start, frame_end, key_code, last,
                  output ready);
endinterface

// ----- hw/rtl/lkpcf_front.sv -----
// front: checks each request, turns each in range (nonzero for a number) into a job for the queue
// depends on lkpcf_pkg and lkpcf_cmd_if
module lkpcf_front
  import lkpcf_pkg::*;
#(
  parameter int DIGIT_COUNT = 4,
  parameter int LED_COUNT   = 8
) (
  lkpcf_cmd_if.sink cmd,
  input  logic      full,
  output logic      push,
  output job_t      job
);

  logic keep;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full && keep;

  always_comb begin
    keep       = 1'b0;
    job.kind   = KIND_SINGLE;
    job.addr   = ADDR_DIGIT + {3'd0, cmd.position, 1'b0};
    job.data   = BYTE_BLANK;
    job.key    = 4'd0;
    job.number = cmd.value[NUM_W-1:0];
    case (cmd.op)
      OP_SET_DIGIT: begin
        keep     = (cmd.position < 4'(DIGIT_COUNT)) && (cmd.value <= DIGIT_MAX);
        job.kind = KIND_PAIR;
        job.data = seg_code(cmd.value[3:0]);
      end
      OP_SET_NUMBER: begin
        keep     = (cmd.value <= NUMBER_MAX) && (cmd.value != 16'd0);
        job.kind = KIND_NUMBER;
      end
      OP_SET_LED: begin
        keep     = (cmd.position < 4'(LED_COUNT)) && (cmd.value <= LED_MAX);
        job.kind = KIND_PAIR;
        job.addr = ADDR_LED + {3'd0, cmd.position, 1'b0};
        job.data = cmd.value[7:0];
      end
      OP_BRIGHTNESS: begin
        keep     = cmd.value <= LEVEL_MAX;
        job.data = CMD_DISPLAY_ON | cmd.value[7:0];
      end
      OP_CLEAR: begin
        keep     = 1'b1;
        job.kind = KIND_CLEAR;
      end
      OP_RESET: begin
        keep     = 1'b1;
        job.kind = KIND_RESET;
      end
      OP_SCAN: begin
        keep     = 1'b1;
        job.data = CMD_READ_KEYS;
        job.key  = decode_keys(cmd.key_bytes);
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/lkpcf_queue.sv -----
// short job queue between the front and the back
// depends on lkpcf_pkg and assert_macros.svh
`include "assert_macros.svh"
module lkpcf_queue
  import lkpcf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `LKPCF_CHK(a_no_overflow, clk, rst, push |-> !full || pop)
  `LKPCF_CHK(a_no_underflow, clk, rst, pop |-> !empty)

endmodule

// ----- hw/rtl/lkpcf_back.sv -----
// back: byte sequencer that plays one job out a byte per cycle while rsp is not stalled
// depends on lkpcf_pkg, lkpcf_byte_if and assert_macros.svh
`include "assert_macros.svh"
module lkpcf_back
  import lkpcf_pkg::*;
#(
  parameter int DIGIT_COUNT = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  job_t         head,
  input  logic         empty,
  output logic         pop,
  lkpcf_byte_if.source rsp
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic              busy;
  job_t              job;
  logic [STEP_W-1:0] step;
  logic [POS_W-1:0]  pos;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;

  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_fs;
  logic              out_fe;
  logic [3:0]        out_key;
  logic              out_last;

  logic [NUM_W+12:0] prod;
  logic [NUM_W-1:0]  quo_next;
  logic [NUM_W-1:0]  digit;
  logic [7:0]        b;
  logic              fs;
  logic              fe;
  logic [3:0]        kc;
  logic              lst;
  logic              adv;
  logic              take;

  assign rsp.valid       = out_valid;
  assign rsp.bus_byte    = out_byte;
  assign rsp.frame_start = out_fs;
  assign rsp.frame_end   = out_fe;
  assign rsp.key_code    = out_key;
  assign rsp.last        = out_last;

  // divide by ten through the reciprocal, remainder on the next byte
  assign prod     = rem * DIV10_RECIP;
  assign quo_next = NUM_W'(prod >> 16);
  assign digit    = rem - ((quo << 3) + (quo << 1));

  always_comb begin
    b   = BYTE_BLANK;
    fs  = 1'b0;
    fe  = 1'b0;
    kc  = 4'd0;
    lst = 1'b0;
    case (job.kind)
      KIND_PAIR: begin
        b   = step[0] ? job.data : job.addr;
        fs  = !step[0];
        fe  = step[0];
        lst = step[0];
      end
      KIND_SINGLE: begin
        b   = job.data;
        fs  = 1'b1;
        fe  = 1'b1;
        kc  = job.key;
        lst = 1'b1;
      end
      KIND_NUMBER: begin
        b   = step[0] ? seg_code(digit[3:0]) : ADDR_DIGIT + 8'({pos, 1'b0});
        fs  = !step[0];
        fe  = step[0];
        lst = step[0] && ((quo == '0) || (pos == '0));
      end
      KIND_CLEAR: begin
        b   = step[0] ? BYTE_BLANK : ADDR_DIGIT + 8'(step);
        fs  = !step[0];
        fe  = step[0];
        lst = step == STEP_W'(2 * DIGIT_COUNT - 1);
      end
      KIND_RESET: begin
        if (step == '0) begin
          b  = CMD_AUTO_INC;
          fs = 1'b1;
          fe = 1'b1;
        end else if (step == STEP_W'(1)) begin
          b  = ADDR_DIGIT;
          fs = 1'b1;
        end else begin
          fe  = step == STEP_W'(RAM_BYTES + 1);
          lst = fe;
        end
      end
      default: lst = 1'b1;
    endcase
  end

  assign adv  = busy && (!out_valid || rsp.ready);
  assign take = !busy || (adv && lst);
  assign pop  = take && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        busy <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= b;
      out_fs   <= fs;
      out_fe   <= fe;
      out_key  <= kc;
      out_last <= lst;
    end
    if (pop) begin
      job  <= head;
      step <= '0;
      pos  <= POS_W'(DIGIT_COUNT - 1);
      rem  <= head.number;
    end else if (adv) begin
      if (job.kind == KIND_NUMBER) begin
        if (!step[0]) begin
          quo  <= quo_next;
          step <= STEP_W'(1);
        end else begin
          rem  <= quo;
          pos  <= pos - 1'b1;
          step <= '0;
        end
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  `LKPCF_CHK_ALWAYS(a_reset_drops_beat, clk, rst |=> !out_valid)
  `LKPCF_CHK(a_key_only_on_scan, clk, rst, out_valid && out_key != 4'd0 |-> out_byte == CMD_READ_KEYS)
  `LKPCF_CHK(a_last_closes_frame, clk, rst, out_valid && out_last |-> out_fe)
  `LKPCF_CHK(a_number_left, clk, rst, busy && job.kind == KIND_NUMBER |-> rem != '0)

endmodule

// ----- hw/rtl/led_key_panel_command_framer_unit.sv -----
// led/key panel command framer: one request in, its command bytes out
// path: an accepted request passes the queue slot, the back's job register and
// the output register to rsp; throughput: one byte per cycle on rsp unless rsp
// stalls; a request has 1 to 18 bytes (set by the back sequencer), a dropped one
// is accepted with no bytes; cmd.ready stays high while the two-job queue has room
// reset (rst, synchronous) empties the queue, idles the sequencer, drops rsp.valid
module led_key_panel_command_framer_unit
  import lkpcf_pkg::*;
#(
  parameter int DIGIT_COUNT = 4,
  parameter int LED_COUNT   = 8
) (
  input  logic         clk,
  input  logic         rst,
  lkpcf_cmd_if.sink    cmd,
  lkpcf_byte_if.source rsp
);

  // front to queue
  logic push;
  job_t push_job;
  logic full;

  // queue to back
  job_t head;
  logic empty;
  logic pop;

  // front: range checks, address and segment lookup, key decode on scans;
  // requests that emit nothing are accepted and never reach the queue
  lkpcf_front #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .LED_COUNT   (LED_COUNT)
  ) u_front (
    .cmd  (cmd),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  // two jobs deep, so the front keeps taking requests while a long
  // reset or clear sequence drains behind it
  lkpcf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // back: walks each job a byte per cycle while rsp is not stalled, into
  // the output register and pulls the next job on the cycle its last byte
  // goes out, so frames of consecutive requests follow without a gap
  lkpcf_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule
